@@ sv/mmhq_pkg.sv @@
// Shared types, request codes and compare helper for the min-max heap queue.
package mmhq_pkg;

  localparam logic [1:0] REQ_INSERT  = 2'd0;
  localparam logic [1:0] REQ_REM_MIN = 2'd1;
  localparam logic [1:0] REQ_REM_MAX = 2'd2;

  localparam int unsigned VAL_W = 32;
  localparam int unsigned OCC_W = 11;

  typedef enum logic [4:0] {
    DP_NONE,
    DP_LOAD,
    DP_SET_ERR,
    DP_INS_INIT,
    DP_UP_P,
    DP_GP_RD,
    DP_GP_MOVE,
    DP_WRX,
    DP_REM_INIT,
    DP_TAKE_LAST,
    DP_SD_INIT,
    DP_SD_SCAN,
    DP_SD_SWAP,
    DP_SD_PSWAP,
    DP_RPT0,
    DP_RPT1,
    DP_RPT2,
    DP_RPT3,
    DP_OUT_LOAD
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic is_ins;
    logic is_rem;
    logic full;
    logic empty;
    logic up_better;
    logic x_better;
    logic i_ge4;
    logic leaf;
    logic node_gone;
    logic scan_more;
    logic bv_better;
    logic best_child;
    logic out_free;
  } dp_status_t;

  // True when a is preferred over b: smaller on min levels, larger on max levels.
  function automatic logic better(input logic signed [VAL_W-1:0] a,
                                  input logic signed [VAL_W-1:0] b,
                                  input logic is_min);
    better = is_min ? (a < b) : (a > b);
  endfunction

endpackage

@@ sv/mmhq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module mmhq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ sv/mmhq_dp.sv @@
// Datapath of the min-max heap queue: heap memory, node indexes, count and result register.
module mmhq_dp import mmhq_pkg::*; #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dp_cmd_t                cmd_i,
  output dp_status_t             status_o,
  input  logic [1:0]             s_tuser_i,
  input  logic [VAL_W-1:0]       s_tdata_i,
  output logic                   m_tvalid_o,
  input  logic                   m_tready_i,
  output logic [3*VAL_W+OCC_W:0] m_data_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = AW + 3;

  logic [1:0]              req_q;
  logic signed [VAL_W-1:0] x_q, bv_q, removed_q, n1_q, n2_q, n3_q;
  logic [CW-1:0]           cnt_q;
  logic [IW-1:0]           i_q, best_q;
  logic                    mode_q, err_q;
  logic [2:0]              k_q;
  logic [1:0]              maxidx_q;
  logic                    m_valid_q;
  logic [3*VAL_W+OCC_W:0]  m_data_q;

  logic                    ram_we;
  logic [IW-1:0]           wr_idx, rd_idx;
  logic signed [VAL_W-1:0] wr_val, rdata;
  logic [IW-1:0]           cnt_x, cnt_p1;
  logic signed [VAL_W-1:0] out_min, out_max;
  logic [1:0]              out_maxidx;

  assign cnt_x  = IW'(cnt_q);
  assign cnt_p1 = cnt_x + IW'(1);

  function automatic logic [IW-1:0] cand(input logic [IW-1:0] i, input logic [2:0] k);
    cand = (k < 3'd2) ? ((i << 1) + IW'(k)) : ((i << 2) + IW'(k - 3'd2));
  endfunction

  // A node is on a min level when its leading one sits at an even bit.
  function automatic logic min_level(input logic [IW-1:0] i);
    logic r;
    r = 1'b0;
    for (int j = 0; j < IW; j += 2) begin
      if (i[j] && ((i >> (j + 1)) == '0)) r = 1'b1;
    end
    min_level = r;
  endfunction

  mmhq_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(AW'(wr_idx - IW'(1))),
    .wdata_i(wr_val),
    .raddr_i(AW'(rd_idx - IW'(1))),
    .rdata_o(rdata)
  );

  always_comb begin
    ram_we = 1'b0;
    wr_idx = i_q;
    wr_val = x_q;
    rd_idx = IW'(1);
    case (cmd_i.op)
      DP_INS_INIT: rd_idx = cnt_p1 >> 1;
      DP_UP_P: begin
        ram_we = better(rdata, x_q, mode_q);
        wr_val = rdata;
      end
      DP_GP_RD:   rd_idx = i_q >> 2;
      DP_GP_MOVE: begin
        ram_we = 1'b1;
        wr_val = rdata;
      end
      DP_WRX:     ram_we = 1'b1;
      DP_REM_INIT: rd_idx = cnt_x;
      DP_SD_INIT:  rd_idx = i_q << 1;
      DP_SD_SCAN:  rd_idx = cand(i_q, k_q + 3'd1);
      DP_SD_SWAP: begin
        ram_we = 1'b1;
        wr_val = bv_q;
        rd_idx = best_q >> 1;
      end
      DP_SD_PSWAP: begin
        ram_we = 1'b1;
        wr_idx = i_q >> 1;
      end
      DP_RPT0: rd_idx = IW'(1);
      DP_RPT1: rd_idx = IW'(2);
      DP_RPT2: rd_idx = IW'(3);
      default: ;
    endcase
  end

  always_comb begin
    out_min    = n1_q;
    out_max    = n1_q;
    out_maxidx = 2'd1;
    if (cnt_q == '0) begin
      out_min = '0;
      out_max = '0;
    end else if (cnt_q == CW'(2)) begin
      out_max    = n2_q;
      out_maxidx = 2'd2;
    end else if (cnt_q != CW'(1)) begin
      out_max    = (n3_q > n2_q) ? n3_q : n2_q;
      out_maxidx = (n3_q > n2_q) ? 2'd3 : 2'd2;
    end
  end

  always_comb begin
    status_o.is_ins     = (req_q == REQ_INSERT);
    status_o.is_rem     = (req_q == REQ_REM_MIN) || (req_q == REQ_REM_MAX);
    status_o.full       = (cnt_q == CW'(CAPACITY));
    status_o.empty      = (cnt_q == '0);
    status_o.up_better  = better(rdata, x_q, mode_q);
    status_o.x_better   = better(x_q, rdata, mode_q);
    status_o.i_ge4      = (i_q >= IW'(4));
    status_o.leaf       = ((i_q << 1) > cnt_x);
    status_o.node_gone  = (i_q > cnt_x);
    status_o.scan_more  = (k_q < 3'd5) && (cand(i_q, k_q + 3'd1) <= cnt_x);
    status_o.bv_better  = better(bv_q, x_q, mode_q);
    status_o.best_child = (best_q < (i_q << 2));
    status_o.out_free   = !m_valid_q || m_tready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == DP_OUT_LOAD) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_tready_i) begin
        m_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        DP_INS_INIT: cnt_q <= cnt_q + CW'(1);
        DP_REM_INIT: cnt_q <= cnt_q - CW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_LOAD: begin
        req_q     <= s_tuser_i;
        x_q       <= s_tdata_i;
        err_q     <= 1'b0;
        removed_q <= '0;
      end
      DP_SET_ERR: err_q <= 1'b1;
      DP_INS_INIT: begin
        i_q    <= cnt_p1;
        mode_q <= min_level(cnt_p1);
      end
      DP_UP_P: begin
        if (better(rdata, x_q, mode_q)) begin
          i_q    <= i_q >> 1;
          mode_q <= !mode_q;
        end
      end
      DP_GP_MOVE: i_q <= i_q >> 2;
      DP_REM_INIT: begin
        mode_q <= (req_q == REQ_REM_MIN);
        if (req_q == REQ_REM_MIN || maxidx_q == 2'd1) begin
          i_q       <= IW'(1);
          removed_q <= n1_q;
        end else if (maxidx_q == 2'd2) begin
          i_q       <= IW'(2);
          removed_q <= n2_q;
        end else begin
          i_q       <= IW'(3);
          removed_q <= n3_q;
        end
      end
      DP_TAKE_LAST: x_q <= rdata;
      DP_SD_INIT:   k_q <= 3'd0;
      DP_SD_SCAN: begin
        if (k_q == 3'd0 || better(rdata, bv_q, mode_q)) begin
          best_q <= cand(i_q, k_q);
          bv_q   <= rdata;
        end
        k_q <= k_q + 3'd1;
      end
      DP_SD_SWAP:  i_q <= best_q;
      DP_SD_PSWAP: x_q <= rdata;
      DP_RPT1: n1_q <= rdata;
      DP_RPT2: n2_q <= rdata;
      DP_RPT3: n3_q <= rdata;
      DP_OUT_LOAD: begin
        maxidx_q <= out_maxidx;
        m_data_q <= {err_q, OCC_W'(cnt_q), out_max, out_min, removed_q};
      end
      default: ;
    endcase
  end

  assign m_tvalid_o = m_valid_q;
  assign m_data_o   = m_data_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_write_in_heap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (wr_idx >= IW'(1)) && (wr_idx <= cnt_x))
    else $error("heap write outside the occupied nodes");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == DP_OUT_LOAD |=> m_valid_q)
    else $error("loaded result not presented");

endmodule

@@ sv/mmhq_ctrl.sv @@
// Control state machine that sequences the heap sifts and the result report.
module mmhq_ctrl import mmhq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_tvalid_i,
  output logic       s_tready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [15:0] {
    S_IDLE     = 16'h0001,
    S_START    = 16'h0002,
    S_UP_P     = 16'h0004,
    S_GP_RD    = 16'h0008,
    S_GP       = 16'h0010,
    S_WRX      = 16'h0020,
    S_REM_LAST = 16'h0040,
    S_SD_CHK   = 16'h0080,
    S_SD_SCAN  = 16'h0100,
    S_SD_DEC   = 16'h0200,
    S_SD_PAR   = 16'h0400,
    S_RPT0     = 16'h0800,
    S_RPT1     = 16'h1000,
    S_RPT2     = 16'h2000,
    S_RPT3     = 16'h4000,
    S_OUT      = 16'h8000
  } state_e;

  state_e state_q, state_d;

  assign s_tready_o = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = DP_NONE;
    case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.op = DP_LOAD;
          state_d  = S_START;
        end
      end
      S_START: begin
        if (status_i.is_ins) begin
          if (status_i.full) begin
            cmd_o.op = DP_SET_ERR;
            state_d  = S_RPT0;
          end else begin
            cmd_o.op = DP_INS_INIT;
            state_d  = status_i.empty ? S_WRX : S_UP_P;
          end
        end else if (status_i.is_rem) begin
          if (status_i.empty) begin
            cmd_o.op = DP_SET_ERR;
            state_d  = S_RPT0;
          end else begin
            cmd_o.op = DP_REM_INIT;
            state_d  = S_REM_LAST;
          end
        end else begin
          state_d = S_RPT0;
        end
      end
      S_UP_P: begin
        cmd_o.op = DP_UP_P;
        state_d  = S_GP_RD;
      end
      S_GP_RD: begin
        if (status_i.i_ge4) begin
          cmd_o.op = DP_GP_RD;
          state_d  = S_GP;
        end else begin
          state_d = S_WRX;
        end
      end
      S_GP: begin
        if (status_i.x_better) begin
          cmd_o.op = DP_GP_MOVE;
          state_d  = S_GP_RD;
        end else begin
          state_d = S_WRX;
        end
      end
      S_WRX: begin
        cmd_o.op = DP_WRX;
        state_d  = S_RPT0;
      end
      S_REM_LAST: begin
        cmd_o.op = DP_TAKE_LAST;
        state_d  = status_i.node_gone ? S_RPT0 : S_SD_CHK;
      end
      S_SD_CHK: begin
        if (status_i.leaf) begin
          state_d = S_WRX;
        end else begin
          cmd_o.op = DP_SD_INIT;
          state_d  = S_SD_SCAN;
        end
      end
      S_SD_SCAN: begin
        cmd_o.op = DP_SD_SCAN;
        if (!status_i.scan_more) state_d = S_SD_DEC;
      end
      S_SD_DEC: begin
        if (status_i.bv_better) begin
          cmd_o.op = DP_SD_SWAP;
          state_d  = status_i.best_child ? S_WRX : S_SD_PAR;
        end else begin
          state_d = S_WRX;
        end
      end
      S_SD_PAR: begin
        // The moved value may belong above its new parent on the opposite level.
        if (status_i.up_better) cmd_o.op = DP_SD_PSWAP;
        state_d = S_SD_CHK;
      end
      S_RPT0: begin
        cmd_o.op = DP_RPT0;
        state_d  = S_RPT1;
      end
      S_RPT1: begin
        cmd_o.op = DP_RPT1;
        state_d  = S_RPT2;
      end
      S_RPT2: begin
        cmd_o.op = DP_RPT2;
        state_d  = S_RPT3;
      end
      S_RPT3: begin
        cmd_o.op = DP_RPT3;
        state_d  = S_OUT;
      end
      S_OUT: begin
        if (status_i.out_free) begin
          cmd_o.op = DP_OUT_LOAD;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ sv/min_max_heap_queue_unit.sv @@
// Top level of the min-max heap double-ended priority queue.
//
// Requests enter on the s_ channel: tuser carries the request kind (insert,
// remove minimum, remove maximum, code 3 does nothing) and tdata the value to
// insert. Every request gives exactly one reply on the m_ channel with the
// removed value, the minimum, the maximum and the occupancy after the request,
// plus an error flag for an insert into a full heap or a removal from an empty
// one (the heap is then left unchanged).
// One request is worked on at a time. An insert climbs the heap by grandparent
// levels and a removal descends it by grandchild levels; the next request is
// taken only once the reply is loaded into the output register. The single
// read port of the heap memory sets the pace: the sift down reads up to six
// children and grandchildren one per cycle, then one parent.
// While a reply waits on a stalled receiver the next request is still taken and
// worked; only its reply then waits until the output register frees.
// Reset empties the heap at once; the memory itself is never cleared.
module min_max_heap_queue_unit import mmhq_pkg::*; #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_tvalid_i,
  output logic          s_tready_o,
  input  logic [31:0]   s_tdata_i,   // value
  input  logic [1:0]    s_tuser_i,   // req_type
  output logic          m_tvalid_o,
  input  logic          m_tready_i,
  output logic [111:0]  m_tdata_o    // removed_value, min_value, max_value, occupancy, error
);

  dp_cmd_t                cmd;
  dp_status_t             status;
  logic [3*VAL_W+OCC_W:0] m_data;

  mmhq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_tvalid_i),
    .s_tready_o(s_tready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  mmhq_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .status_o  (status),
    .s_tuser_i (s_tuser_i),
    .s_tdata_i (s_tdata_i),
    .m_tvalid_o(m_tvalid_o),
    .m_tready_i(m_tready_i),
    .m_data_o  (m_data)
  );

  assign m_tdata_o = {4'b0000, m_data};

endmodule

@@ tb/tb_min_max_heap_queue_unit.sv @@
// Self-checking testbench for the min-max heap queue with a built-in heap predictor.
module tb_min_max_heap_queue_unit;
  import mmhq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HEAP_CAP = 1024;
  localparam logic [1:0] REQ_NOP = 2'd3;

  typedef struct packed {
    logic                    error;
    logic [OCC_W-1:0]        occupancy;
    logic signed [VAL_W-1:0] max_value;
    logic signed [VAL_W-1:0] min_value;
    logic signed [VAL_W-1:0] removed_value;
  } reply_t;

  // Predicts heap replies and checks them against the block's output.
  class heap_scoreboard;
    logic signed [VAL_W-1:0] nodes [1:HEAP_CAP];
    int unsigned             count;
    reply_t                  pending_replies [$];
    int unsigned             mismatches;

    function void reset_heap();
      count = 0;
      mismatches = 0;
      pending_replies.delete();
    endfunction

    function bit prefers(logic signed [VAL_W-1:0] a, logic signed [VAL_W-1:0] b,
                         bit want_min);
      return want_min ? (a < b) : (a > b);
    endfunction

    function void swap_at(int unsigned a, int unsigned b);
      logic signed [VAL_W-1:0] t;
      t = nodes[a];
      nodes[a] = nodes[b];
      nodes[b] = t;
    endfunction

    function bit min_depth(int unsigned i);
      int unsigned d;
      d = 0;
      while (i > 1) begin
        i = i >> 1;
        d++;
      end
      return d[0] == 1'b0;
    endfunction

    function void climb_grand(int unsigned i, bit want_min);
      while (i >= 4 && prefers(nodes[i], nodes[i/4], want_min)) begin
        swap_at(i, i / 4);
        i = i / 4;
      end
    endfunction

    function void climb(int unsigned i);
      bit mn;
      if (i <= 1) return;
      mn = min_depth(i);
      if (prefers(nodes[i/2], nodes[i], mn)) begin
        swap_at(i, i / 2);
        climb_grand(i / 2, !mn);
      end else begin
        climb_grand(i, mn);
      end
    endfunction

    function void sink(int unsigned i, bit want_min);
      int unsigned best;
      int unsigned c;
      forever begin
        if (2 * i > count) return;
        best = 2 * i;
        for (int k = 1; k < 6; k++) begin
          c = (k == 1) ? 2 * i + 1 : 4 * i + k - 2;
          if (c <= count && prefers(nodes[c], nodes[best], want_min)) best = c;
        end
        if (!prefers(nodes[best], nodes[i], want_min)) return;
        swap_at(i, best);
        if (best < 4 * i) return;
        if (prefers(nodes[best/2], nodes[best], want_min)) swap_at(best, best / 2);
        i = best;
      end
    endfunction

    function int unsigned max_index();
      if (count == 1) return 1;
      if (count == 2) return 2;
      return (nodes[3] > nodes[2]) ? 3 : 2;
    endfunction

    function void note_request(logic [1:0] kind, logic signed [VAL_W-1:0] value);
      reply_t r;
      int unsigned node;
      r = '0;
      if (kind == REQ_INSERT) begin
        if (count >= HEAP_CAP) begin
          r.error = 1'b1;
        end else begin
          count++;
          nodes[count] = value;
          climb(count);
        end
      end else if (kind == REQ_REM_MIN || kind == REQ_REM_MAX) begin
        if (count == 0) begin
          r.error = 1'b1;
        end else begin
          node = (kind == REQ_REM_MIN) ? 1 : max_index();
          r.removed_value = nodes[node];
          nodes[node] = nodes[count];
          count--;
          if (node <= count) sink(node, kind == REQ_REM_MIN);
        end
      end
      if (count != 0) begin
        r.min_value = nodes[1];
        r.max_value = nodes[max_index()];
      end
      r.occupancy = count[OCC_W-1:0];
      pending_replies.push_back(r);
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected reply %h", got);
        return;
      end
      want = pending_replies.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"ERROR: reply mismatch removed %0d/%0d min %0d/%0d max %0d/%0d",
                    " occ %0d/%0d err %0b/%0b"},
                   want.removed_value, got.removed_value, want.min_value, got.min_value,
                   want.max_value, got.max_value, want.occupancy, got.occupancy,
                   want.error, got.error);
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_tvalid_i = 1'b0;
  logic               s_tready_o;
  logic [31:0]        s_tdata_i = '0;
  logic [1:0]         s_tuser_i = '0;
  logic               m_tvalid_o;
  logic               m_tready_i = 1'b0;
  logic [111:0]       m_tdata_o;

  heap_scoreboard     sb;
  bit                 stall_long = 1'b0;

  always #2 clk_i = ~clk_i;

  min_max_heap_queue_unit #(.CAPACITY(HEAP_CAP)) i_dut (
    .clk_i, .rst_ni, .s_tvalid_i, .s_tready_o, .s_tdata_i, .s_tuser_i,
    .m_tvalid_o, .m_tready_i, .m_tdata_o
  );

  // Offer one request and hold it until accepted; the prediction is made at acceptance.
  task automatic send_request(logic [1:0] kind, logic [31:0] value);
    @(negedge clk_i);
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= kind;
    s_tdata_i  <= value;
    do @(posedge clk_i); while (!s_tready_o);
    sb.note_request(kind, value);
  endtask

  task automatic idle_sender(int unsigned cycles);
    @(negedge clk_i);
    s_tvalid_i <= 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  task automatic wait_drained();
    idle_sender(0);
    while (sb.pending_replies.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($urandom_range(0, 8)) - 32'd4;
      3, 4: return 32'($urandom_range(0, 40));
      default: return $urandom;
    endcase
  endfunction

  task automatic random_phase(int unsigned n, int unsigned ins_weight, int unsigned gap_max);
    int unsigned burst;
    int unsigned r;
    logic [1:0]  kind;
    while (n > 0) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && n > 0) begin
        r = $urandom_range(0, 99);
        if (r < ins_weight) kind = REQ_INSERT;
        else if (r < 98) kind = (r[0]) ? REQ_REM_MIN : REQ_REM_MAX;
        else kind = REQ_NOP;
        send_request(kind, pick_value());
        burst--;
        n--;
      end
      if (gap_max != 0) idle_sender($urandom_range(0, gap_max));
    end
  endtask

  // Receiver: random stall pattern, with one long hold-off on request.
  initial begin
    forever begin
      @(negedge clk_i);
      if (stall_long) begin
        m_tready_i <= 1'b0;
        repeat (400) @(negedge clk_i);
        stall_long = 1'b0;
      end
      m_tready_i <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid_o && m_tready_i) sb.check_reply(reply_t'(m_tdata_o[107:0]));
  end

  initial begin
    #3_000_000;
    $display("min_max_heap_queue_unit test failed");
    $finish;
  end

  initial begin
    logic [31:0] v;
    sb = new();
    sb.reset_heap();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // Directed: removals from empty, extremes, ties, no-op code.
    send_request(REQ_REM_MIN, 32'h0);
    send_request(REQ_REM_MAX, 32'hffff_ffff);
    send_request(REQ_NOP, 32'h0);
    send_request(REQ_INSERT, 32'h7fff_ffff);
    send_request(REQ_REM_MAX, 32'h0);
    send_request(REQ_INSERT, 32'h8000_0000);
    send_request(REQ_INSERT, 32'h0);
    send_request(REQ_INSERT, 32'hffff_ffff);
    send_request(REQ_INSERT, 32'h5);
    send_request(REQ_INSERT, 32'h5);
    send_request(REQ_INSERT, 32'h5);
    send_request(REQ_NOP, 32'h1234);
    send_request(REQ_REM_MAX, 32'h0);
    send_request(REQ_REM_MAX, 32'h0);
    send_request(REQ_REM_MIN, 32'h0);
    send_request(REQ_REM_MIN, 32'h0);
    send_request(REQ_REM_MIN, 32'h0);
    send_request(REQ_REM_MAX, 32'h0);
    send_request(REQ_REM_MAX, 32'h0);
    wait_drained();
    // Receiver holds off while inserts keep coming, so the block must stall its input.
    stall_long = 1'b1;
    random_phase(60, 90, 0);
    wait_drained();
    random_phase(200, 55, 6);
    wait_drained();
    // Fill to capacity, probe the full error, then drain a good part of it.
    while (sb.count < HEAP_CAP) begin
      v = (sb.count % 16 == 0) ? $urandom : 32'($urandom_range(0, 50));
      send_request(REQ_INSERT, v);
    end
    send_request(REQ_INSERT, 32'h8000_0000);
    send_request(REQ_INSERT, 32'h7fff_ffff);
    random_phase(120, 50, 3);
    random_phase(250, 10, 2);
    wait_drained();
    repeat (100) @(negedge clk_i);
    if (sb.mismatches == 0 && sb.pending_replies.size() == 0) begin
      $display("min_max_heap_queue_unit test passed");
    end else begin
      $display("min_max_heap_queue_unit test failed");
    end
    $finish;
  end
endmodule
